// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// wrappers for concurrent assertions, empty in synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/mvsl_pkg.sv -----
// ---------------------------------------------------------------------------
// mvsl_pkg
// shared types and constants of the mains voltage safety lockout
// ---------------------------------------------------------------------------
package mvsl_pkg;

    // operation codes
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_ACK   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_ZERO_POINT  = 3'd0;
    localparam logic [2:0] CFG_VOLT_SCALE  = 3'd1;
    localparam logic [2:0] CFG_CRIT_MIN    = 3'd2;
    localparam logic [2:0] CFG_HIGH_MIN    = 3'd3;
    localparam logic [2:0] CFG_HIGH_MAX    = 3'd4;
    localparam logic [2:0] CFG_MED_MIN     = 3'd5;
    localparam logic [2:0] CFG_MED_MAX     = 3'd6;
    localparam logic [2:0] CFG_AUTO_LOCK   = 3'd7;

    // alert levels
    localparam logic [2:0] LVL_NONE     = 3'd0;
    localparam logic [2:0] LVL_LOW      = 3'd1;
    localparam logic [2:0] LVL_MEDIUM   = 3'd2;
    localparam logic [2:0] LVL_HIGH     = 3'd3;
    localparam logic [2:0] LVL_CRITICAL = 3'd4;

    // behavior constants
    localparam logic [19:0] LOCKOUT_MS   = 20'd30000;
    localparam logic [13:0] LOW_ALERT_Q4 = 14'd800;
    localparam logic [7:0]  UNSAFE_LIMIT = 8'd3;

    localparam int unsigned SHIFT = 11;
    localparam logic [13:0] VOLT_MAX = 14'h3fff;

    typedef struct packed {
        logic [11:0] zero_point;
        logic [15:0] volt_scale;
        logic [13:0] crit_min;
        logic [13:0] high_min;
        logic [13:0] high_max;
        logic [13:0] med_min;
        logic [13:0] med_max;
        logic        auto_lock;
    } t_cfg;

    // converted item handed from the conversion stage to the control stage
    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [13:0] volts;
    } t_volt_item;

endpackage

// ----- design/mvsl_cfg.sv -----
// ---------------------------------------------------------------------------
// mvsl_cfg
// configuration register file, written through a plain write port
// ---------------------------------------------------------------------------
module mvsl_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output mvsl_pkg::t_cfg      o_cfg
);

    mvsl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_point <= 12'd2048;
            r_cfg.volt_scale <= 16'd4096;
            r_cfg.crit_min   <= 14'd4160;
            r_cfg.high_min   <= 14'd3040;
            r_cfg.high_max   <= 14'd4000;
            r_cfg.med_min    <= 14'd1440;
            r_cfg.med_max    <= 14'd2240;
            r_cfg.auto_lock  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvsl_pkg::CFG_ZERO_POINT: r_cfg.zero_point <= i_cfg_data[11:0];
                mvsl_pkg::CFG_VOLT_SCALE: r_cfg.volt_scale <= i_cfg_data;
                mvsl_pkg::CFG_CRIT_MIN:   r_cfg.crit_min   <= i_cfg_data[13:0];
                mvsl_pkg::CFG_HIGH_MIN:   r_cfg.high_min   <= i_cfg_data[13:0];
                mvsl_pkg::CFG_HIGH_MAX:   r_cfg.high_max   <= i_cfg_data[13:0];
                mvsl_pkg::CFG_MED_MIN:    r_cfg.med_min    <= i_cfg_data[13:0];
                mvsl_pkg::CFG_MED_MAX:    r_cfg.med_max    <= i_cfg_data[13:0];
                mvsl_pkg::CFG_AUTO_LOCK:  r_cfg.auto_lock  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/mvsl_conv.sv -----
// ---------------------------------------------------------------------------
// mvsl_conv
// sample to voltage conversion: |sample - zero| * scale >> 11, saturated
// ---------------------------------------------------------------------------
module mvsl_conv (
    input  logic                    i_valid,
    input  logic [1:0]              i_op,
    input  logic [11:0]             i_sample,
    input  mvsl_pkg::t_cfg          i_cfg,
    output mvsl_pkg::t_volt_item    o_item
);

    logic [11:0] n_mag;
    logic [27:0] n_prod;
    logic [16:0] n_shifted;
    logic [13:0] n_volts;

    always_comb begin
        n_mag     = (i_sample >= i_cfg.zero_point) ? (i_sample - i_cfg.zero_point)
                                                   : (i_cfg.zero_point - i_sample);
        n_prod    = {16'd0, n_mag} * {12'd0, i_cfg.volt_scale};
        n_shifted = n_prod[27:mvsl_pkg::SHIFT];
        n_volts   = (|n_shifted[16:14]) ? mvsl_pkg::VOLT_MAX : n_shifted[13:0];
    end

    assign o_item.valid = i_valid;
    assign o_item.op    = i_op;
    assign o_item.volts = n_volts;

endmodule

// ----- design/mvsl_ctrl.sv -----
// ---------------------------------------------------------------------------
// mvsl_ctrl
// alert band sorting, safety state, unsafe run counter, lockout timer and
// the result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mvsl_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mvsl_pkg::t_cfg          i_cfg,
    input  mvsl_pkg::t_volt_item    i_item,
    output logic                    o_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_check_passed,
    output logic [13:0]             o_voltage_q4,
    output logic [2:0]              o_alert_level,
    output logic [1:0]              o_safety_state,
    output logic                    o_can_proceed,
    output logic [19:0]             o_lockout_left,
    output logic [7:0]              o_unsafe_run
);

    typedef enum logic [1:0] {
        ST_SAFE    = 2'd0,
        ST_WARNING = 2'd1,
        ST_DANGER  = 2'd2,
        ST_LOCKOUT = 2'd3
    } t_mode;

    t_mode       r_mode;
    logic        r_ack;
    logic [7:0]  r_cnt;
    logic [19:0] r_timer;
    logic [13:0] r_last_v;
    logic [2:0]  r_last_l;

    logic        r_out_valid;
    logic        r_check_passed;
    logic [13:0] r_voltage_q4;
    logic [2:0]  r_alert_level;
    logic [1:0]  r_safety_state;
    logic        r_can_proceed;
    logic [19:0] r_lockout_left;
    logic [7:0]  r_unsafe_run;

    t_mode       n_mode;
    logic        n_ack;
    logic [7:0]  n_cnt;
    logic [19:0] n_timer;
    logic [13:0] n_last_v;
    logic [2:0]  n_last_l;
    logic        n_passed;
    logic [2:0]  n_level;
    logic        fire;

    assign o_ready = !r_out_valid || !i_out_stall;
    assign fire    = i_item.valid && o_ready;

    always_comb begin
        if (i_item.volts >= i_cfg.crit_min) begin
            n_level = mvsl_pkg::LVL_CRITICAL;
        end else if (i_item.volts >= i_cfg.high_min && i_item.volts <= i_cfg.high_max) begin
            n_level = mvsl_pkg::LVL_HIGH;
        end else if (i_item.volts >= i_cfg.med_min && i_item.volts <= i_cfg.med_max) begin
            n_level = mvsl_pkg::LVL_MEDIUM;
        end else if (i_item.volts >= mvsl_pkg::LOW_ALERT_Q4) begin
            n_level = mvsl_pkg::LVL_LOW;
        end else begin
            n_level = mvsl_pkg::LVL_NONE;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_ack    = r_ack;
        n_cnt    = r_cnt;
        n_timer  = r_timer;
        n_last_v = r_last_v;
        n_last_l = r_last_l;
        n_passed = 1'b0;
        case (i_item.op)
            mvsl_pkg::OP_CHECK: begin
                // a running lockout rejects the check without sampling
                if (!(r_mode == ST_LOCKOUT && r_timer != 20'd0)) begin
                    n_last_v = i_item.volts;
                    n_last_l = n_level;
                    if (r_mode == ST_LOCKOUT) begin
                        n_mode = ST_SAFE;
                    end
                    if (n_level == mvsl_pkg::LVL_NONE) begin
                        n_cnt    = 8'd0;
                        n_passed = 1'b1;
                    end else begin
                        n_cnt = (r_cnt == 8'hff) ? r_cnt : r_cnt + 8'd1;
                        if (n_level >= mvsl_pkg::LVL_HIGH) begin
                            n_mode = ST_DANGER;
                        end else if (n_level == mvsl_pkg::LVL_MEDIUM) begin
                            n_mode = ST_WARNING;
                        end else begin
                            n_mode = ST_SAFE;
                        end
                        if (i_cfg.auto_lock &&
                            (n_mode == ST_DANGER || n_cnt >= mvsl_pkg::UNSAFE_LIMIT)) begin
                            n_mode  = ST_LOCKOUT;
                            n_timer = mvsl_pkg::LOCKOUT_MS;
                        end
                    end
                end
            end
            mvsl_pkg::OP_TICK: begin
                if (r_mode == ST_LOCKOUT) begin
                    if (r_timer > 20'd1) begin
                        n_timer = r_timer - 20'd1;
                    end else begin
                        n_timer = 20'd0;
                        n_mode  = ST_SAFE;
                    end
                end
            end
            mvsl_pkg::OP_ACK: begin
                n_ack   = 1'b1;
                n_mode  = ST_SAFE;
                n_timer = 20'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_SAFE;
            r_ack       <= 1'b0;
            r_cnt       <= 8'd0;
            r_timer     <= 20'd0;
            r_last_v    <= 14'd0;
            r_last_l    <= mvsl_pkg::LVL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_item.valid;
            end
            if (fire) begin
                r_mode         <= n_mode;
                r_ack          <= n_ack;
                r_cnt          <= n_cnt;
                r_timer        <= n_timer;
                r_last_v       <= n_last_v;
                r_last_l       <= n_last_l;
                r_check_passed <= n_passed;
                r_voltage_q4   <= n_last_v;
                r_alert_level  <= n_last_l;
                r_safety_state <= n_mode;
                r_can_proceed  <= n_ack && (n_mode == ST_SAFE || n_mode == ST_WARNING);
                r_lockout_left <= (n_mode == ST_LOCKOUT) ? n_timer : 20'd0;
                r_unsafe_run   <= n_cnt;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_check_passed = r_check_passed;
    assign o_voltage_q4   = r_voltage_q4;
    assign o_alert_level  = r_alert_level;
    assign o_safety_state = r_safety_state;
    assign o_can_proceed  = r_can_proceed;
    assign o_lockout_left = r_lockout_left;
    assign o_unsafe_run   = r_unsafe_run;

    // the timer runs exactly while the block is locked out
    `ASSERT_ALWAYS(a_timer_lockout, i_clk, i_rst_n,
        (r_mode == ST_LOCKOUT) == (r_timer != 20'd0))
    // a passed check always reports no alert level and a cleared unsafe run
    `ASSERT_IMPLIES(a_pass_clean, i_clk, i_rst_n, r_out_valid && r_check_passed,
        r_alert_level == mvsl_pkg::LVL_NONE && r_unsafe_run == 8'd0)
    // remaining lockout time is only reported in lockout
    `ASSERT_IMPLIES(a_left_lockout, i_clk, i_rst_n, r_out_valid && r_lockout_left != 20'd0,
        r_safety_state == ST_LOCKOUT)
    // measurement is never allowed in danger or lockout
    `ASSERT_IMPLIES(a_proceed_safe, i_clk, i_rst_n, r_out_valid && r_can_proceed,
        r_safety_state == ST_SAFE || r_safety_state == ST_WARNING)

endmodule

// ----- design/mains_voltage_safety_lockout.sv -----
// ---------------------------------------------------------------------------
// mains_voltage_safety_lockout
// voltage safety check with alert bands and timed lockout
// ---------------------------------------------------------------------------
// Takes one transaction per clock while not stalled and returns exactly one
// result per transaction, in order. The input register feeds a single
// combinational pass (one 12x16 multiply for the scaled voltage, the band
// compares and the update of the safety state, unsafe run counter and
// lockout timer) into the result register. Back-to-back transactions see
// each other's state updates. The input stalls only while the result
// register is full and stalled. Configuration registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while no
// transaction is in flight, which the block itself does not enforce.
module mains_voltage_safety_lockout (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_adc_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_check_passed,
    output logic [13:0] o_voltage_q4,
    output logic [2:0]  o_alert_level,
    output logic [1:0]  o_safety_state,
    output logic        o_can_proceed,
    output logic [19:0] o_lockout_left,
    output logic [7:0]  o_unsafe_run
);

    mvsl_pkg::t_cfg       cfg;
    mvsl_pkg::t_volt_item volt_item;
    logic                 ctrl_ready;

    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [11:0] r_sample;
    logic        in_ready;

    assign in_ready   = !r_in_valid || ctrl_ready;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_op     <= i_operation;
            r_sample <= i_adc_sample;
        end
    end

    mvsl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mvsl_conv u_conv (
        .i_valid    (r_in_valid),
        .i_op       (r_op),
        .i_sample   (r_sample),
        .i_cfg      (cfg),
        .o_item     (volt_item)
    );

    mvsl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_item         (volt_item),
        .o_ready        (ctrl_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_check_passed (o_check_passed),
        .o_voltage_q4   (o_voltage_q4),
        .o_alert_level  (o_alert_level),
        .o_safety_state (o_safety_state),
        .o_can_proceed  (o_can_proceed),
        .o_lockout_left (o_lockout_left),
        .o_unsafe_run   (o_unsafe_run)
    );

endmodule

// ----- dv/tb_mains_voltage_safety_lockout.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mains_voltage_safety_lockout
// self-checking bench: directed and random transactions against an in-bench
// model of the conversion, alert bands, unsafe run counter and lockout timer
// ---------------------------------------------------------------------------
module tb_mains_voltage_safety_lockout;

    localparam logic [1:0] ST_SAFE    = 2'd0;
    localparam logic [1:0] ST_WARNING = 2'd1;
    localparam logic [1:0] ST_DANGER  = 2'd2;
    localparam logic [1:0] ST_LOCKOUT = 2'd3;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned PHASE_ITEMS = 325;

    typedef struct packed {
        logic        passed;
        logic [13:0] volts;
        logic [2:0]  level;
        logic [1:0]  state;
        logic        proceed;
        logic [19:0] left;
        logic [7:0]  run;
    } t_lockout_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [11:0] i_adc_sample;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_check_passed;
    logic [13:0] o_voltage_q4;
    logic [2:0]  o_alert_level;
    logic [1:0]  o_safety_state;
    logic        o_can_proceed;
    logic [19:0] o_lockout_left;
    logic [7:0]  o_unsafe_run;

    mains_voltage_safety_lockout dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_adc_sample   (i_adc_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_check_passed (o_check_passed),
        .o_voltage_q4   (o_voltage_q4),
        .o_alert_level  (o_alert_level),
        .o_safety_state (o_safety_state),
        .o_can_proceed  (o_can_proceed),
        .o_lockout_left (o_lockout_left),
        .o_unsafe_run   (o_unsafe_run)
    );

    always #2 i_clk = ~i_clk;

    // model state and configuration copy
    mvsl_pkg::t_cfg cfg_model;
    logic [1:0]  mode_q;
    logic        ack_seen;
    logic [7:0]  unsafe_cnt;
    logic [19:0] lock_timer;
    logic [13:0] last_volts;
    logic [2:0]  last_lvl;

    t_lockout_status pending_status[$];
    int unsigned     error_count = 0;
    int unsigned     result_count = 0;
    int unsigned     cycle_count = 0;
    int unsigned     stall_left = 0;
    bit              idle_on = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    // applies one operation to the model and returns the status it reports
    function automatic t_lockout_status step_safety(input logic [1:0] op,
                                                    input logic [11:0] sample);
        t_lockout_status r;
        logic [11:0] mag;
        logic [27:0] scaled;
        logic [13:0] v;
        logic [2:0]  lvl;
        r.passed = 1'b0;
        case (op)
            mvsl_pkg::OP_CHECK: begin
                if (mode_q == ST_LOCKOUT && lock_timer == 20'd0) begin
                    mode_q = ST_SAFE;
                end
                if (mode_q != ST_LOCKOUT) begin
                    mag = (sample >= cfg_model.zero_point) ? sample - cfg_model.zero_point
                                                           : cfg_model.zero_point - sample;
                    scaled = (mag * cfg_model.volt_scale) >> mvsl_pkg::SHIFT;
                    v = (scaled > 28'(mvsl_pkg::VOLT_MAX)) ? mvsl_pkg::VOLT_MAX
                                                           : scaled[13:0];
                    if (v >= cfg_model.crit_min) begin
                        lvl = mvsl_pkg::LVL_CRITICAL;
                    end else if (v >= cfg_model.high_min && v <= cfg_model.high_max) begin
                        lvl = mvsl_pkg::LVL_HIGH;
                    end else if (v >= cfg_model.med_min && v <= cfg_model.med_max) begin
                        lvl = mvsl_pkg::LVL_MEDIUM;
                    end else if (v >= mvsl_pkg::LOW_ALERT_Q4) begin
                        lvl = mvsl_pkg::LVL_LOW;
                    end else begin
                        lvl = mvsl_pkg::LVL_NONE;
                    end
                    last_volts = v;
                    last_lvl = lvl;
                    if (lvl == mvsl_pkg::LVL_NONE) begin
                        unsafe_cnt = 8'd0;
                        r.passed = 1'b1;
                    end else begin
                        if (unsafe_cnt != 8'hff) begin
                            unsafe_cnt = unsafe_cnt + 8'd1;
                        end
                        if (lvl >= mvsl_pkg::LVL_HIGH) begin
                            mode_q = ST_DANGER;
                        end else if (lvl == mvsl_pkg::LVL_MEDIUM) begin
                            mode_q = ST_WARNING;
                        end else begin
                            mode_q = ST_SAFE;
                        end
                        if (cfg_model.auto_lock &&
                            (mode_q == ST_DANGER ||
                             unsafe_cnt >= mvsl_pkg::UNSAFE_LIMIT)) begin
                            mode_q = ST_LOCKOUT;
                            lock_timer = mvsl_pkg::LOCKOUT_MS;
                        end
                    end
                end
            end
            mvsl_pkg::OP_TICK: begin
                if (mode_q == ST_LOCKOUT) begin
                    if (lock_timer > 20'd1) begin
                        lock_timer = lock_timer - 20'd1;
                    end else begin
                        lock_timer = 20'd0;
                        mode_q = ST_SAFE;
                    end
                end
            end
            mvsl_pkg::OP_ACK: begin
                ack_seen = 1'b1;
                mode_q = ST_SAFE;
                lock_timer = 20'd0;
            end
            default: begin
            end
        endcase
        r.volts = last_volts;
        r.level = last_lvl;
        r.state = mode_q;
        r.proceed = ack_seen && (mode_q < ST_DANGER);
        r.left = (mode_q == ST_LOCKOUT) ? lock_timer : 20'd0;
        r.run = unsafe_cnt;
        return r;
    endfunction

    // leaves valid high after acceptance; settle or the next send takes over
    task automatic send_item(input logic [1:0] op, input logic [11:0] sample);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_adc_sample <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_status.push_back(step_safety(op, sample));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            mvsl_pkg::CFG_ZERO_POINT: cfg_model.zero_point = value[11:0];
            mvsl_pkg::CFG_VOLT_SCALE: cfg_model.volt_scale = value;
            mvsl_pkg::CFG_CRIT_MIN:   cfg_model.crit_min = value[13:0];
            mvsl_pkg::CFG_HIGH_MIN:   cfg_model.high_min = value[13:0];
            mvsl_pkg::CFG_HIGH_MAX:   cfg_model.high_max = value[13:0];
            mvsl_pkg::CFG_MED_MIN:    cfg_model.med_min = value[13:0];
            mvsl_pkg::CFG_MED_MAX:    cfg_model.med_max = value[13:0];
            mvsl_pkg::CFG_AUTO_LOCK:  cfg_model.auto_lock = value[0];
            default: begin
            end
        endcase
    endtask

    task automatic write_defaults();
        write_cfg(mvsl_pkg::CFG_ZERO_POINT, 16'd2048);
        write_cfg(mvsl_pkg::CFG_VOLT_SCALE, 16'd4096);
        write_cfg(mvsl_pkg::CFG_CRIT_MIN, 16'd4160);
        write_cfg(mvsl_pkg::CFG_HIGH_MIN, 16'd3040);
        write_cfg(mvsl_pkg::CFG_HIGH_MAX, 16'd4000);
        write_cfg(mvsl_pkg::CFG_MED_MIN, 16'd1440);
        write_cfg(mvsl_pkg::CFG_MED_MAX, 16'd2240);
        write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'd1);
    endtask

    // mostly checks, half of them close to the zero point so safe runs occur
    task automatic send_random_item();
        int unsigned pick;
        int          s;
        logic [1:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            op = mvsl_pkg::OP_CHECK;
        end else if (pick < 77) begin
            op = mvsl_pkg::OP_TICK;
        end else if (pick < 96) begin
            op = mvsl_pkg::OP_ACK;
        end else begin
            op = OP_UNUSED;
        end
        if ($urandom_range(0, 1) == 0) begin
            s = int'($urandom_range(0, 4095));
        end else begin
            s = int'(cfg_model.zero_point) + int'($urandom_range(0, 1200)) - 600;
            if (s < 0) s = 0;
            if (s > 4095) s = 4095;
        end
        send_item(op, 12'(s));
    endtask

    task automatic random_burst(input int unsigned n);
        repeat (n) send_random_item();
    endtask

    // defaults give volts_q4 = 2 * |sample - 2048|
    task automatic test_first_checks();
        send_item(mvsl_pkg::OP_CHECK, 12'd2048);     // safe but not yet acknowledged
        send_item(mvsl_pkg::OP_TICK, 12'hfff);       // tick outside lockout
        send_item(OP_UNUSED, 12'h555);
        send_item(mvsl_pkg::OP_ACK, 12'haaa);
        send_item(mvsl_pkg::OP_CHECK, 12'd2848);     // medium: warning
        send_item(mvsl_pkg::OP_CHECK, 12'd1548);     // low: back to safe, run of two
        send_item(mvsl_pkg::OP_CHECK, 12'd4095);     // gap between high and critical
        send_item(mvsl_pkg::OP_CHECK, 12'd0);        // refused during lockout
        send_item(mvsl_pkg::OP_TICK, 12'd0);
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd0);        // run not cleared by acknowledge
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd2048);
        send_item(mvsl_pkg::OP_CHECK, 12'd3648);     // high: danger locks at once
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd948);
    endtask

    task automatic test_band_edges();
        settle();
        write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd2447);     // just under the low alert
        send_item(mvsl_pkg::OP_CHECK, 12'd2448);     // low alert exactly
        send_item(mvsl_pkg::OP_CHECK, 12'd2768);     // medium lower edge
        send_item(mvsl_pkg::OP_CHECK, 12'd3168);     // medium upper edge
        send_item(mvsl_pkg::OP_CHECK, 12'd3169);
        send_item(mvsl_pkg::OP_CHECK, 12'd528);      // high lower edge
        send_item(mvsl_pkg::OP_CHECK, 12'd48);       // high upper edge
        send_item(mvsl_pkg::OP_CHECK, 12'd47);
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        settle();
        write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'd1);
    endtask

    task automatic test_config_extremes();
        settle();
        write_cfg(mvsl_pkg::CFG_ZERO_POINT, 16'd0);
        write_cfg(mvsl_pkg::CFG_VOLT_SCALE, 16'hffff);
        send_item(mvsl_pkg::OP_CHECK, 12'd4095);     // saturates and goes critical
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd1);
        random_burst(12);
        settle();
        write_cfg(mvsl_pkg::CFG_ZERO_POINT, 16'd4095);
        write_cfg(mvsl_pkg::CFG_VOLT_SCALE, 16'd0);
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd0);
        random_burst(12);
        settle();
        write_cfg(mvsl_pkg::CFG_ZERO_POINT, 16'd2048);
        write_cfg(mvsl_pkg::CFG_VOLT_SCALE, 16'd4096);
        write_cfg(mvsl_pkg::CFG_CRIT_MIN, 16'd0);
        write_cfg(mvsl_pkg::CFG_HIGH_MIN, 16'd0);
        write_cfg(mvsl_pkg::CFG_HIGH_MAX, 16'd0);
        write_cfg(mvsl_pkg::CFG_MED_MIN, 16'd0);
        write_cfg(mvsl_pkg::CFG_MED_MAX, 16'd0);
        write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'd0);
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd2048);     // zero volts is still critical
        random_burst(12);
        settle();
        write_cfg(mvsl_pkg::CFG_CRIT_MIN, 16'h3fff);
        write_cfg(mvsl_pkg::CFG_HIGH_MIN, 16'h3fff);
        write_cfg(mvsl_pkg::CFG_HIGH_MAX, 16'h3fff);
        write_cfg(mvsl_pkg::CFG_MED_MAX, 16'h3fff);
        send_item(mvsl_pkg::OP_CHECK, 12'd2048);
        send_item(mvsl_pkg::OP_CHECK, 12'd0);
        random_burst(12);
        settle();
        // inverted bands match nothing
        write_cfg(mvsl_pkg::CFG_HIGH_MAX, 16'd0);
        write_cfg(mvsl_pkg::CFG_MED_MIN, 16'h3fff);
        write_cfg(mvsl_pkg::CFG_MED_MAX, 16'd0);
        write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'd1);
        random_burst(20);
        settle();
        write_defaults();
    endtask

    task automatic test_no_auto_lockout();
        settle();
        write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'd0);
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        repeat (260) send_item(mvsl_pkg::OP_CHECK, 12'd3648);   // run saturates in danger
        send_item(mvsl_pkg::OP_TICK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd2848);
        send_item(mvsl_pkg::OP_CHECK, 12'd1548);
        send_item(mvsl_pkg::OP_CHECK, 12'd2048);
        settle();
        write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'd1);
    endtask

    task automatic test_lockout_expiry();
        send_item(mvsl_pkg::OP_ACK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd3648);
        repeat (int'(mvsl_pkg::LOCKOUT_MS))
            send_item(mvsl_pkg::OP_TICK, 12'($urandom_range(0, 4095)));
        send_item(mvsl_pkg::OP_TICK, 12'd0);
        send_item(mvsl_pkg::OP_CHECK, 12'd2048);
    endtask

    task automatic test_random_traffic();
        int unsigned crit;
        int unsigned hmax;
        int unsigned hmin;
        int unsigned mmax;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                settle();
                crit = $urandom_range(3000, 12000);
                hmax = $urandom_range(crit / 2, crit);
                hmin = $urandom_range(hmax / 2, hmax);
                mmax = $urandom_range(800, hmin);
                write_cfg(mvsl_pkg::CFG_ZERO_POINT, 16'($urandom_range(1700, 2400)));
                write_cfg(mvsl_pkg::CFG_VOLT_SCALE, 16'($urandom_range(2048, 8192)));
                write_cfg(mvsl_pkg::CFG_CRIT_MIN, 16'(crit));
                write_cfg(mvsl_pkg::CFG_HIGH_MIN, 16'(hmin));
                write_cfg(mvsl_pkg::CFG_HIGH_MAX, 16'(hmax));
                write_cfg(mvsl_pkg::CFG_MED_MIN, 16'($urandom_range(0, mmax)));
                write_cfg(mvsl_pkg::CFG_MED_MAX, 16'(mmax));
                write_cfg(mvsl_pkg::CFG_AUTO_LOCK, 16'($urandom_range(0, 3) != 0));
            end
            if (phase == 5) begin
                idle_on = 1'b0;
            end
            random_burst(PHASE_ITEMS);
        end
    endtask

    // result checking and receiver stall
    always @(posedge i_clk) begin : result_monitor
        t_lockout_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result with no transaction pending");
            end else begin
                want = pending_status.pop_front();
                if (o_check_passed !== want.passed)
                    report_mismatch($sformatf("check_passed %0d want %0d",
                                              o_check_passed, want.passed));
                if (o_voltage_q4 !== want.volts)
                    report_mismatch($sformatf("voltage_q4 %0d want %0d",
                                              o_voltage_q4, want.volts));
                if (o_alert_level !== want.level)
                    report_mismatch($sformatf("alert_level %0d want %0d",
                                              o_alert_level, want.level));
                if (o_safety_state !== want.state)
                    report_mismatch($sformatf("safety_state %0d want %0d",
                                              o_safety_state, want.state));
                if (o_can_proceed !== want.proceed)
                    report_mismatch($sformatf("can_proceed %0d want %0d",
                                              o_can_proceed, want.proceed));
                if (o_lockout_left !== want.left)
                    report_mismatch($sformatf("lockout_left %0d want %0d",
                                              o_lockout_left, want.left));
                if (o_unsafe_run !== want.run)
                    report_mismatch($sformatf("unsafe_run %0d want %0d",
                                              o_unsafe_run, want.run));
            end
            result_count++;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (i_rst_n && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL mains_voltage_safety_lockout");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= mvsl_pkg::CFG_ZERO_POINT;
        i_cfg_data <= 16'd0;
        i_in_valid <= 1'b0;
        i_operation <= mvsl_pkg::OP_CHECK;
        i_adc_sample <= 12'd0;
        i_out_stall <= 1'b0;
        cfg_model = '{zero_point: 12'd2048, volt_scale: 16'd4096, crit_min: 14'd4160,
                      high_min: 14'd3040, high_max: 14'd4000, med_min: 14'd1440,
                      med_max: 14'd2240, auto_lock: 1'b1};
        mode_q = ST_SAFE;
        ack_seen = 1'b0;
        unsafe_cnt = 8'd0;
        lock_timer = 20'd0;
        last_volts = 14'd0;
        last_lvl = mvsl_pkg::LVL_NONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_checks();
        test_band_edges();
        test_config_extremes();
        test_no_auto_lockout();
        test_lockout_expiry();
        test_random_traffic();

        settle();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS mains_voltage_safety_lockout");
        end else begin
            $display("FAIL mains_voltage_safety_lockout");
        end
        $finish;
    end

endmodule
